// ----- rtl/sofl_pkg.sv -----
package sofl_pkg;

  localparam int unsigned PageBytes  = 4096;
  localparam int unsigned MaxObjects = 256;
  localparam int unsigned SizeW      = 13;
  localparam int unsigned OffW       = 12;
  localparam int unsigned CntW       = 9;
  localparam int unsigned IdxW       = 8;
  localparam int unsigned Depth      = 256;
  localparam int unsigned SizeMin    = 16;
  localparam int unsigned SizeMax    = 4096;
  localparam int unsigned SizeReset  = 64;
  localparam int unsigned CapReset   = (PageBytes - PageBytes / SizeReset) / SizeReset;
  localparam int unsigned DivSteps   = SizeW;
  localparam int unsigned DivCntW    = 4;

  // register index of object_size in the APB map
  localparam logic RegObjectSize = 1'b0;

  typedef enum logic {
    MODE_ALLOC,
    MODE_FREE
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_FULL,
    STATUS_BAD_FREE
  } status_e;

  typedef enum logic [1:0] {
    DIV_OFFSET,
    DIV_PAGE,
    DIV_PAGE_LESS_MARKS
  } div_src_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALLOC_RD,
    ST_ALLOC_MUL,
    ST_FREE_START,
    ST_FREE_DIV,
    ST_DONE,
    ST_CAP_START1,
    ST_CAP_DIV1,
    ST_CAP_START2,
    ST_CAP_DIV2,
    ST_CAP_LOAD
  } state_e;

  typedef struct packed {
    logic     in_load;
    logic     div_start;
    div_src_e div_src;
    logic     cap_load;
    logic     stk_read;
    logic     mul_load;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/sofl_ctrl.sv -----
module sofl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  sofl_pkg::mode_e    in_mode_i,
  input  logic               cfg_wr_i,
  input  sofl_pkg::sts_t     sts_i,
  output logic               in_ready_o,
  output sofl_pkg::cmd_t     cmd_o
);

  sofl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sofl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      sofl_pkg::ST_IDLE: begin
        in_ready_o = !cfg_wr_i;
        if (in_valid_i && !cfg_wr_i) begin
          cmd_o.in_load = 1'b1;
          state_d = (in_mode_i == sofl_pkg::MODE_FREE) ? sofl_pkg::ST_FREE_START
                                                       : sofl_pkg::ST_ALLOC_RD;
        end
      end
      sofl_pkg::ST_ALLOC_RD: begin
        cmd_o.stk_read = 1'b1;
        state_d = sofl_pkg::ST_ALLOC_MUL;
      end
      sofl_pkg::ST_ALLOC_MUL: begin
        cmd_o.mul_load = 1'b1;
        state_d = sofl_pkg::ST_DONE;
      end
      sofl_pkg::ST_FREE_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_src   = sofl_pkg::DIV_OFFSET;
        state_d = sofl_pkg::ST_FREE_DIV;
      end
      sofl_pkg::ST_FREE_DIV: begin
        if (!sts_i.div_busy) state_d = sofl_pkg::ST_DONE;
      end
      sofl_pkg::ST_DONE: begin
        // hold the result until the output register can take it
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = sofl_pkg::ST_IDLE;
        end
      end
      sofl_pkg::ST_CAP_START1: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_src   = sofl_pkg::DIV_PAGE;
        state_d = sofl_pkg::ST_CAP_DIV1;
      end
      sofl_pkg::ST_CAP_DIV1: begin
        if (!sts_i.div_busy) state_d = sofl_pkg::ST_CAP_START2;
      end
      sofl_pkg::ST_CAP_START2: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_src   = sofl_pkg::DIV_PAGE_LESS_MARKS;
        state_d = sofl_pkg::ST_CAP_DIV2;
      end
      sofl_pkg::ST_CAP_DIV2: begin
        if (!sts_i.div_busy) state_d = sofl_pkg::ST_CAP_LOAD;
      end
      sofl_pkg::ST_CAP_LOAD: begin
        cmd_o.cap_load = 1'b1;
        state_d = sofl_pkg::ST_IDLE;
      end
      default: state_d = sofl_pkg::ST_IDLE;
    endcase
    // a size write restarts the capacity computation
    if (cfg_wr_i) begin
      state_d = sofl_pkg::ST_CAP_START1;
    end
  end

endmodule

// ----- rtl/sofl_dp.sv -----
module sofl_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sofl_pkg::cmd_t                cmd_i,
  output sofl_pkg::sts_t                sts_o,
  input  logic                          cfg_wr_i,
  input  logic [sofl_pkg::SizeW-1:0]    cfg_size_i,
  output logic [sofl_pkg::SizeW-1:0]    size_o,
  input  sofl_pkg::mode_e               in_mode_i,
  input  logic [sofl_pkg::OffW-1:0]     in_offset_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [sofl_pkg::OffW-1:0]     out_offset_o,
  output sofl_pkg::status_e             out_status_o,
  output logic [sofl_pkg::CntW-1:0]     out_in_use_o
);

  localparam int unsigned SizeW = sofl_pkg::SizeW;
  localparam int unsigned OffW  = sofl_pkg::OffW;
  localparam int unsigned CntW  = sofl_pkg::CntW;
  localparam int unsigned IdxW  = sofl_pkg::IdxW;
  localparam int unsigned Depth = sofl_pkg::Depth;

  // configuration and pool state
  logic [SizeW-1:0]     size_q;
  logic [CntW-1:0]      cap_q;
  logic [CntW-1:0]      in_use_q;
  logic [Depth-1:0]     valid_q;

  // item registers
  sofl_pkg::mode_e      mode_q;
  logic [OffW-1:0]      offset_q;

  // stack memory and read port
  logic [IdxW-1:0]      mem [Depth];
  logic [IdxW-1:0]      rd_data_q;
  logic                 rd_valid_q;
  logic [IdxW-1:0]      rd_addr_q;
  logic [OffW-1:0]      prod_q;

  // divider
  logic                        div_busy_q;
  logic [sofl_pkg::DivCntW-1:0] div_cnt_q;
  logic [SizeW-1:0]            dvd_q;
  logic [SizeW-1:0]            rem_q;
  logic [SizeW-1:0]            quo_q;

  // output register
  logic                 out_valid_q;
  logic [OffW-1:0]      out_offset_q;
  sofl_pkg::status_e    out_status_q;
  logic [CntW-1:0]      out_in_use_q;

  logic [SizeW-1:0]     eff_size;
  logic [SizeW:0]       rem_sh;
  logic [SizeW:0]       rem_diff;
  logic                 rem_ge;
  logic [SizeW-1:0]     dividend;
  logic [IdxW-1:0]      stk_idx;
  logic [IdxW+SizeW-1:0] prod_full;
  logic                 full;
  logic                 bad;
  logic [CntW-1:0]      use_dec;
  logic [CntW-1:0]      use_next;
  logic [OffW-1:0]      res_offset;
  sofl_pkg::status_e    res_status;
  logic                 free_ok;

  always_comb begin
    if (size_q < SizeW'(sofl_pkg::SizeMin)) begin
      eff_size = SizeW'(sofl_pkg::SizeMin);
    end else if (size_q > SizeW'(sofl_pkg::SizeMax)) begin
      eff_size = SizeW'(sofl_pkg::SizeMax);
    end else begin
      eff_size = size_q;
    end
  end

  // restoring division, one quotient bit a cycle
  assign rem_sh   = {rem_q, dvd_q[SizeW-1]};
  assign rem_ge   = rem_sh >= {1'b0, eff_size};
  assign rem_diff = rem_sh - {1'b0, eff_size};

  always_comb begin
    case (cmd_i.div_src)
      sofl_pkg::DIV_OFFSET:          dividend = {1'b0, offset_q};
      sofl_pkg::DIV_PAGE:            dividend = SizeW'(sofl_pkg::PageBytes);
      sofl_pkg::DIV_PAGE_LESS_MARKS: dividend = SizeW'(sofl_pkg::PageBytes) - quo_q;
      default:                       dividend = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= sofl_pkg::DivCntW'(sofl_pkg::DivSteps - 1);
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q - 1'b1;
      if (div_cnt_q == '0) div_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q <= dividend;
      rem_q <= '0;
      quo_q <= '0;
    end else if (div_busy_q) begin
      dvd_q <= {dvd_q[SizeW-2:0], 1'b0};
      rem_q <= rem_ge ? rem_diff[SizeW-1:0] : rem_sh[SizeW-1:0];
      quo_q <= {quo_q[SizeW-2:0], rem_ge};
    end
  end

  // item capture, stack read and offset multiply
  assign stk_idx   = rd_valid_q ? rd_data_q : rd_addr_q;
  assign prod_full = {{SizeW{1'b0}}, stk_idx} * {{IdxW{1'b0}}, eff_size};

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      mode_q   <= in_mode_i;
      offset_q <= in_offset_i;
    end
    if (cmd_i.stk_read) begin
      rd_data_q  <= mem[in_use_q[IdxW-1:0]];
      rd_valid_q <= valid_q[in_use_q[IdxW-1:0]];
      rd_addr_q  <= in_use_q[IdxW-1:0];
    end
    if (cmd_i.mul_load) begin
      prod_q <= prod_full[OffW-1:0];
    end
  end

  // result of the item in flight
  assign full    = in_use_q >= cap_q;
  assign bad     = (in_use_q == '0) || (quo_q >= SizeW'(cap_q));
  assign use_dec = in_use_q - 1'b1;
  assign free_ok = cmd_i.commit && (mode_q == sofl_pkg::MODE_FREE) && !bad;

  always_comb begin
    if (mode_q == sofl_pkg::MODE_ALLOC) begin
      res_status = full ? sofl_pkg::STATUS_FULL : sofl_pkg::STATUS_OK;
      res_offset = full ? '0 : prod_q;
      use_next   = full ? in_use_q : in_use_q + 1'b1;
    end else begin
      res_status = bad ? sofl_pkg::STATUS_BAD_FREE : sofl_pkg::STATUS_OK;
      res_offset = '0;
      use_next   = bad ? in_use_q : use_dec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_ok) begin
      mem[use_dec[IdxW-1:0]] <= quo_q[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SizeW'(sofl_pkg::SizeReset);
      cap_q       <= CntW'(sofl_pkg::CapReset);
      in_use_q    <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_i) size_q <= cfg_size_i;
      if (cmd_i.cap_load) begin
        cap_q <= (quo_q > SizeW'(sofl_pkg::MaxObjects)) ? CntW'(sofl_pkg::MaxObjects)
                                                        : quo_q[CntW-1:0];
      end
      if (cmd_i.commit) in_use_q <= use_next;
      // an empty page falls back to identity order
      if (free_ok) begin
        if (use_dec == '0) begin
          valid_q <= '0;
        end else begin
          valid_q[use_dec[IdxW-1:0]] <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_offset_q <= res_offset;
      out_status_q <= res_status;
      out_in_use_q <= use_next;
    end
  end

  assign sts_o.div_busy = div_busy_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign size_o       = size_q;
  assign out_valid_o  = out_valid_q;
  assign out_offset_o = out_offset_q;
  assign out_status_o = out_status_q;
  assign out_in_use_o = out_in_use_q;

endmodule

// ----- rtl/slab_object_free_list.sv -----
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata: free_offset; tuser: mode
// m_axis    out  tvalid/tready          tdata: object_offset, in_use; tuser: status
// apb       in   psel/penable/pready    object_size at address 0
//
// Allocate passes through stack read, multiply and commit before its result shows.
// Free shows its result after the 13-step restoring divider has computed
// offset / size. Both commit only once the output register is free.
// A write to object_size recomputes capacity with two divisions
// while s_axis_tready stays low. The next item is taken while a result waits.
// Reset empties the pool, restores identity order and sets object_size to 64.
module slab_object_free_list (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] free_offset, [15:12] zero
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [11:0] object_offset, [20:12] in_use, [23:21] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sofl_pkg::cmd_t                   cmd;
  sofl_pkg::sts_t                   sts;
  logic                             cfg_wr;
  logic [sofl_pkg::SizeW-1:0]       size;
  logic [sofl_pkg::OffW-1:0]        out_offset;
  sofl_pkg::status_e                out_status;
  logic [sofl_pkg::CntW-1:0]        out_in_use;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == sofl_pkg::RegObjectSize);
  assign prdata = (paddr[2] == sofl_pkg::RegObjectSize)
                ? {{(32 - sofl_pkg::SizeW){1'b0}}, size} : '0;

  sofl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (sofl_pkg::mode_e'(s_axis_tuser)),
    .cfg_wr_i   (cfg_wr),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  sofl_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_wr_i     (cfg_wr),
    .cfg_size_i   (pwdata[sofl_pkg::SizeW-1:0]),
    .size_o       (size),
    .in_mode_i    (sofl_pkg::mode_e'(s_axis_tuser)),
    .in_offset_i  (s_axis_tdata[sofl_pkg::OffW-1:0]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_offset_o (out_offset),
    .out_status_o (out_status),
    .out_in_use_o (out_in_use)
  );

  assign m_axis_tdata = {3'b000, out_in_use, out_offset};
  assign m_axis_tuser = out_status;

endmodule

// ----- rtl/sofl_checker.sv -----
module sofl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic        pready
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  // size write holds off requests while capacity is recomputed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[2] == sofl_pkg::RegObjectSize)
    |=> !s_axis_tready)
    else $error("request taken during capacity update");

  // a failed request never returns an offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != sofl_pkg::STATUS_OK) |-> m_axis_tdata[11:0] == 12'd0)
    else $error("offset on failed request");

endmodule

bind slab_object_free_list sofl_checker u_sofl_checker (.*);

// ----- sim/tb_slab_object_free_list.sv -----
`timescale 1ns / 1ps

module tb_slab_object_free_list;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned OffW        = sofl_pkg::OffW;
  localparam int unsigned CntW        = sofl_pkg::CntW;
  localparam int unsigned IdxW        = sofl_pkg::IdxW;
  localparam int unsigned SizeW       = sofl_pkg::SizeW;
  localparam int unsigned Depth       = sofl_pkg::Depth;

  typedef struct packed {
    sofl_pkg::mode_e mode;
    logic [OffW-1:0] offset;
  } request_t;

  typedef struct packed {
    logic [OffW-1:0]   offset;
    sofl_pkg::status_e status;
    logic [CntW-1:0]   in_use;
  } result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [11:0] free_offset, [15:12] zero
  logic        s_axis_tuser  = 1'b0; // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [11:0] object_offset, [20:12] in_use, [23:21] zero
  logic [1:0]  m_axis_tuser;         // [1:0] status
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  slab_object_free_list dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  request_t    pending_requests[$];
  result_t     predicted_results[$];
  int unsigned tx_idle_pct = 36;
  int unsigned rx_idle_pct = 56;
  int unsigned mismatches  = 0;
  int unsigned cycles      = 0;

  // shadow of the page state
  logic [IdxW-1:0]  free_stack [Depth];
  int unsigned      live_count;
  logic [SizeW-1:0] size_reg;
  int unsigned      pool_cap;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_size(logic [SizeW-1:0] raw);
    int unsigned s;
    s = 32'(raw);
    if (s < sofl_pkg::SizeMin) s = sofl_pkg::SizeMin;
    if (s > sofl_pkg::SizeMax) s = sofl_pkg::SizeMax;
    return s;
  endfunction

  function automatic int unsigned capacity_of(logic [SizeW-1:0] raw);
    int unsigned s;
    int unsigned c;
    s = clamp_size(raw);
    c = (sofl_pkg::PageBytes - sofl_pkg::PageBytes / s) / s;
    if (c > sofl_pkg::MaxObjects) c = sofl_pkg::MaxObjects;
    return c;
  endfunction

  function automatic void restore_identity();
    for (int i = 0; i < Depth; i++) free_stack[i] = IdxW'(i);
  endfunction

  function automatic result_t apply_request(request_t req);
    result_t     res;
    int unsigned s;
    int unsigned idx;
    s = clamp_size(size_reg);
    res.offset = '0;
    res.status = sofl_pkg::STATUS_OK;
    if (req.mode == sofl_pkg::MODE_ALLOC) begin
      if (live_count >= pool_cap) begin
        res.status = sofl_pkg::STATUS_FULL;
      end else begin
        idx = 32'(free_stack[live_count % Depth]);
        live_count++;
        res.offset = OffW'(idx * s);
      end
    end else begin
      idx = 32'(req.offset) / s;
      if (live_count == 0 || idx >= pool_cap) begin
        res.status = sofl_pkg::STATUS_BAD_FREE;
      end else begin
        live_count--;
        free_stack[live_count % Depth] = IdxW'(idx);
        // page drained: back to a fresh layout
        if (live_count == 0) restore_identity();
      end
    end
    res.in_use = CntW'(live_count);
    return res;
  endfunction

  task automatic add_request(sofl_pkg::mode_e mode, logic [OffW-1:0] offset);
    request_t req;
    req.mode   = mode;
    req.offset = offset;
    pending_requests.push_back(req);
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || s_axis_tvalid || predicted_results.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_object_size(logic [SizeW-1:0] value);
    wait_idle();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * int'(sofl_pkg::RegObjectSize));
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    size_reg = value;
    pool_cap = capacity_of(value);
    @(negedge clk_i);
  endtask

  function automatic logic [SizeW-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return SizeW'(sofl_pkg::SizeMin);
      1:       return SizeW'($urandom_range(sofl_pkg::SizeMax, 8191));
      2:       return SizeW'($urandom_range(0, sofl_pkg::SizeMin - 1));
      3:       return SizeW'($urandom_range(sofl_pkg::SizeMin + 1, 100));
      default: return SizeW'($urandom_range(101, 1400));
    endcase
  endfunction

  // bursts of allocates then frees of slots up to one past capacity, with some noise mixed in
  task automatic queue_bursts(int unsigned n, logic [SizeW-1:0] size);
    int unsigned s;
    int unsigned c;
    int unsigned count;
    int unsigned len;
    int unsigned idx;
    s = clamp_size(size);
    c = capacity_of(size);
    count = 0;
    while (count < n) begin
      if ($urandom_range(0, 9) == 0) begin
        add_request(sofl_pkg::mode_e'($urandom_range(0, 1)), OffW'($urandom));
        count++;
      end else begin
        len = $urandom_range(1, c + 4);
        for (int i = 0; i < len; i++) add_request(sofl_pkg::MODE_ALLOC, OffW'($urandom));
        count += len;
        len = $urandom_range(1, c + 4);
        for (int i = 0; i < len; i++) begin
          idx = $urandom_range(0, c);
          add_request(sofl_pkg::MODE_FREE, OffW'(idx * s + $urandom_range(0, s - 1)));
        end
        count += len;
      end
    end
  endtask

  initial begin
    logic [SizeW-1:0] size;
    size_reg   = SizeW'(sofl_pkg::SizeReset);
    pool_cap   = capacity_of(SizeW'(sofl_pkg::SizeReset));
    live_count = 0;
    restore_identity();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty pool, range check and return to identity order at reset size
    add_request(sofl_pkg::MODE_FREE, 12'd0);
    add_request(sofl_pkg::MODE_FREE, 12'd4095);
    add_request(sofl_pkg::MODE_ALLOC, 12'd4095);
    add_request(sofl_pkg::MODE_ALLOC, 12'd0);
    add_request(sofl_pkg::MODE_FREE, 12'd69);
    add_request(sofl_pkg::MODE_FREE, 12'd4095);
    add_request(sofl_pkg::MODE_FREE, 12'd0);
    add_request(sofl_pkg::MODE_ALLOC, 12'd0);
    add_request(sofl_pkg::MODE_ALLOC, 12'd0);
    // shrink while objects are live
    write_object_size(13'd2048);
    add_request(sofl_pkg::MODE_ALLOC, 12'd0);
    add_request(sofl_pkg::MODE_FREE, 12'd2048);
    add_request(sofl_pkg::MODE_FREE, 12'd100);
    // sizes below the floor clamp to the minimum
    write_object_size(13'd0);
    add_request(sofl_pkg::MODE_ALLOC, 12'd0);
    add_request(sofl_pkg::MODE_FREE, 12'd4095);
    add_request(sofl_pkg::MODE_ALLOC, 12'd0);
    // sizes above the ceiling leave no room at all
    write_object_size(13'd8191);
    add_request(sofl_pkg::MODE_ALLOC, 12'd0);
    add_request(sofl_pkg::MODE_FREE, 12'd0);
    write_object_size(13'd4096);
    add_request(sofl_pkg::MODE_ALLOC, 12'd0);
    write_object_size(13'd16);
    add_request(sofl_pkg::MODE_FREE, 12'd0);
    add_request(sofl_pkg::MODE_FREE, 12'd16);
    add_request(sofl_pkg::MODE_FREE, 12'd32);

    for (int seg = 0; seg < 3; seg++) begin
      wait_idle();
      case (seg)
        0: begin tx_idle_pct = 36; rx_idle_pct = 56; end
        1: begin tx_idle_pct = 56; rx_idle_pct = 36; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int ph = 0; ph < 4; ph++) begin
        size = pick_size();
        write_object_size(size);
        queue_bursts(capacity_of(size) > 100 ? 300 : 100, size);
      end
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, pending_requests[0].offset};
        s_axis_tuser  <= pending_requests[0].mode;
        void'(pending_requests.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : scoreboard
    request_t req;
    result_t  want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        req.mode   = sofl_pkg::mode_e'(s_axis_tuser);
        req.offset = s_axis_tdata[OffW-1:0];
        predicted_results.push_back(apply_request(req));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result, offset %0d status %0d in_use %0d", $time,
                   m_axis_tdata[11:0], m_axis_tuser, m_axis_tdata[20:12]);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (m_axis_tdata[11:0] !== want.offset) begin
            $display("%0t: object_offset expected %0d got %0d", $time, want.offset,
                     m_axis_tdata[11:0]);
            mismatches++;
          end
          if (m_axis_tuser !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tdata[20:12] !== want.in_use) begin
            $display("%0t: in_use expected %0d got %0d", $time, want.in_use,
                     m_axis_tdata[20:12]);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, predicted_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
